// ----- src/wtdf_pkg.sv -----
// ----------------------------------------------------------------------------
// wtdf_pkg
// shared types and constants for the window time-domain feature block
// ----------------------------------------------------------------------------
package wtdf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEN_W    = 11;
	localparam int THR_W    = 35;
	localparam int SQ_W     = 41;
	localparam int WL_W     = 26;
	localparam int ABS_W    = 26;
	localparam int WD_W     = 27;
	localparam int SSC_W    = 10;
	localparam int OUT_W    = 16;
	localparam int LEN_MIN  = 4;
	localparam int LEN_MAX  = 1024;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;

	localparam logic REG_WINDOW_LENGTH   = 1'b0;
	localparam logic REG_SLOPE_THRESHOLD = 1'b1;

	// one closed window handed from front to back
	typedef struct packed {
		logic [SQ_W-1:0]  sq_sum;
		logic [WL_W-1:0]  diff_sum;
		logic [ABS_W-1:0] abs_sum;
		logic [WD_W-1:0]  wd_sum;
		logic [SSC_W-1:0] slope_cnt;
		logic [LEN_W-1:0] len;
	} window_t;

	// finished result
	typedef struct packed {
		logic [SQ_W-1:0]  square_integral;
		logic [OUT_W-1:0] root_mean_square;
		logic [WL_W-1:0]  waveform_length;
		logic [OUT_W-1:0] mean_absolute;
		logic [OUT_W-1:0] weighted_mean_absolute;
		logic [SSC_W-1:0] slope_changes;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV_SQ, ST_DIV_ABS, ST_DIV_WD, ST_SQRT, ST_DONE
	} back_state_t;

endpackage

// ----- src/window_time_domain_features.sv -----
// path: a window's result passes the queue, three divisions and a square root, then
// loads into the result register once the previous result has been popped
// throughput: one sample per cycle while the queue has room; the back end handles
// one window at a time, so short windows fill the queue and full stalls input
// reset: asynchronous, clears sums, queue and result valid flag; window_length = 256
// ----------------------------------------------------------------------------
// window_time_domain_features
// windowed time-domain features: energy, rms, waveform length, mav, wmav, ssc
// ----------------------------------------------------------------------------
module window_time_domain_features (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample stream
	input  logic                        push,
	output logic                        full,
	input  logic signed [wtdf_pkg::SAMPLE_W-1:0] sample,
	// result stream
	output logic                        empty,
	input  logic                        pop,
	output logic [wtdf_pkg::SQ_W-1:0]   square_integral,
	output logic [wtdf_pkg::OUT_W-1:0]  root_mean_square,
	output logic [wtdf_pkg::WL_W-1:0]   waveform_length,
	output logic [wtdf_pkg::OUT_W-1:0]  mean_absolute,
	output logic [wtdf_pkg::OUT_W-1:0]  weighted_mean_absolute,
	output logic [wtdf_pkg::SSC_W-1:0]  slope_changes,
	// configuration writes
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [wtdf_pkg::THR_W-1:0]  cfg_data
);
	import wtdf_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic [THR_W-1:0] thr_q;
	logic             take;
	logic             win_valid, win_take, q_nonempty, q_afull, res_valid;
	window_t          win, q_rdata;
	result_t          res;

	// config registers, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(256);
			thr_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WINDOW_LENGTH:   len_q <= cfg_data[LEN_W-1:0];
				REG_SLOPE_THRESHOLD: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front accepts while the window queue has room
	assign full = q_afull;
	assign take = push && !full;

	logic [LEN_W-1:0] len_eff;
	// clamp to the legal range for accumulation compares
	always_comb begin
		len_eff = len_q;
		if (len_q < LEN_W'(LEN_MIN)) len_eff = LEN_W'(LEN_MIN);
		if (len_q > LEN_W'(LEN_MAX)) len_eff = LEN_W'(LEN_MAX);
	end

	wtdf_front u_front (
		.clk, .arst_n, .take, .sample, .len(len_eff), .thr(thr_q),
		.win_valid, .win
	);

	wtdf_queue u_queue (
		.clk, .arst_n, .wr(win_valid), .wdata(win), .rd(win_take), .rdata(q_rdata),
		.nonempty(q_nonempty), .almost_full(q_afull)
	);

	wtdf_back u_back (
		.clk, .arst_n, .win_avail(q_nonempty), .win(q_rdata), .win_take,
		.res_valid, .res, .res_take(pop && res_valid)
	);

	assign empty                  = !res_valid;
	assign square_integral        = res.square_integral;
	assign root_mean_square       = res.root_mean_square;
	assign waveform_length        = res.waveform_length;
	assign mean_absolute          = res.mean_absolute;
	assign weighted_mean_absolute = res.weighted_mean_absolute;
	assign slope_changes          = res.slope_changes;

	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		len_eff >= LEN_W'(LEN_MIN) && len_eff <= LEN_W'(LEN_MAX)) else $error("bad length");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty |=> $past(res_valid)) else $error("pop without result");
	a_full_take: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !take) else $error("sample taken while full");

endmodule

// ----- src/wtdf_front.sv -----
// ----------------------------------------------------------------------------
// wtdf_front
// accumulates samples into window sums, emits one closed window per window
// ----------------------------------------------------------------------------
module wtdf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic signed [wtdf_pkg::SAMPLE_W-1:0] sample,
	input  logic [wtdf_pkg::LEN_W-1:0]  len,
	input  logic [wtdf_pkg::THR_W-1:0]  thr,
	output logic                        win_valid,
	output wtdf_pkg::window_t           win
);
	import wtdf_pkg::*;

	logic [LEN_W-1:0] idx_q;
	logic signed [SAMPLE_W-1:0] prev_q, prev2_q;
	logic [SQ_W-1:0]  sq_q;
	logic [WL_W-1:0]  diff_q;
	logic [ABS_W-1:0] abs_q;
	logic [WD_W-1:0]  wd_q;
	logic [SSC_W-1:0] ssc_q;

	logic [SAMPLE_W:0]    ax, adiff;
	logic signed [SAMPLE_W:0] d1, d2, dx;
	logic signed [2*SAMPLE_W+1:0] prod;
	logic [2*SAMPLE_W+1:0] sqv;
	logic [LEN_W+1:0] i4, l3;
	logic mid, last, hit;

	always_comb begin
		ax    = sample[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({sample[SAMPLE_W-1], sample}))
		                           : {1'b0, sample};
		sqv   = (2*SAMPLE_W+2)'(ax) * (2*SAMPLE_W+2)'(ax);
		dx    = $signed({sample[SAMPLE_W-1], sample}) - $signed({prev_q[SAMPLE_W-1], prev_q});
		adiff = dx[SAMPLE_W] ? (SAMPLE_W+1)'(-dx) : (SAMPLE_W+1)'(dx);
		d1    = $signed({prev_q[SAMPLE_W-1], prev_q}) - $signed({prev2_q[SAMPLE_W-1], prev2_q});
		d2    = -dx;
		prod  = (2*SAMPLE_W+2)'(d1) * (2*SAMPLE_W+2)'(d2);
		hit   = !prod[2*SAMPLE_W+1] && ({1'b0, prod} >= (2*SAMPLE_W+3)'(thr))
		        && (THR_W <= 2*SAMPLE_W+2 || thr[THR_W-1:2*SAMPLE_W+2] == '0);
		i4    = {idx_q, 2'b00};
		l3    = (LEN_W+2)'(len) + (LEN_W+2)'({len, 1'b0});
		mid   = (i4 >= (LEN_W+2)'(len)) && (i4 <= l3);
		last  = (idx_q + 1'b1) >= len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; prev_q <= '0; prev2_q <= '0;
			sq_q <= '0; diff_q <= '0; abs_q <= '0; wd_q <= '0; ssc_q <= '0;
			win_valid <= 1'b0;
		end else begin
			win_valid <= 1'b0;
			if (take) begin
				if (last) begin
					win_valid     <= 1'b1;
					win.sq_sum    <= sq_q + SQ_W'(sqv);
					win.abs_sum   <= abs_q + ABS_W'(ax);
					win.wd_sum    <= wd_q + (mid ? WD_W'({ax, 1'b0}) : WD_W'(ax));
					win.diff_sum  <= (idx_q != '0) ? diff_q + WL_W'(adiff) : diff_q;
					win.slope_cnt <= (idx_q >= LEN_W'(2) && hit) ? ssc_q + 1'b1 : ssc_q;
					win.len       <= len;
					idx_q <= '0; prev_q <= '0; prev2_q <= '0;
					sq_q <= '0; diff_q <= '0; abs_q <= '0; wd_q <= '0; ssc_q <= '0;
				end else begin
					idx_q   <= idx_q + 1'b1;
					prev2_q <= prev_q;
					prev_q  <= sample;
					sq_q    <= sq_q + SQ_W'(sqv);
					abs_q   <= abs_q + ABS_W'(ax);
					wd_q    <= wd_q + (mid ? WD_W'({ax, 1'b0}) : WD_W'(ax));
					if (idx_q != '0)
						diff_q <= diff_q + WL_W'(adiff);
					if (idx_q >= LEN_W'(2) && hit)
						ssc_q <= ssc_q + 1'b1;
				end
			end
		end
	end

	property p_idx_below_len;
		@(posedge clk) disable iff (!arst_n) (idx_q <= LEN_W'(LEN_MAX));
	endproperty
	a_idx_below_len: assert property (p_idx_below_len) else $error("window index overrun");

	a_win_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |=> !win_valid || $past(take)) else $error("window pulse without sample");

	a_clear_after_win: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |-> idx_q == '0) else $error("sums not cleared at window end");

endmodule

// ----- src/wtdf_queue.sv -----
// ----------------------------------------------------------------------------
// wtdf_queue
// short queue of closed windows between front and back
// ----------------------------------------------------------------------------
module wtdf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  wtdf_pkg::window_t wdata,
	input  logic              rd,
	output wtdf_pkg::window_t rdata,
	output logic              nonempty,
	output logic              almost_full
);
	import wtdf_pkg::*;

	window_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign rdata       = mem_q[rp_q];
	assign nonempty    = cnt_q != '0;
	// a window may already be in flight in the front register
	assign almost_full = cnt_q >= (QPTR_W+1)'(QDEPTH - 1);

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> cnt_q < (QPTR_W+1)'(QDEPTH) || rd) else $error("window queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> nonempty) else $error("window queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QDEPTH)) else $error("window queue count out of range");

endmodule

// ----- src/wtdf_back.sv -----
// ----------------------------------------------------------------------------
// wtdf_back
// per-window divisions and square root, one result register
// ----------------------------------------------------------------------------
module wtdf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              win_avail,
	input  wtdf_pkg::window_t win,
	output logic              win_take,
	output logic              res_valid,
	output wtdf_pkg::result_t res,
	input  logic              res_take
);
	import wtdf_pkg::*;

	localparam int DIV_W  = SQ_W;
	localparam int DCNT_W = $clog2(DIV_W + 1);
	localparam int RAD_W  = 42;
	localparam int ROOT_W = RAD_W / 2;
	localparam int RCNT_W = $clog2(ROOT_W + 1);

	back_state_t st_q, st_d;
	window_t     w_q;
	logic [DIV_W-1:0]  quo_q;
	logic [LEN_W+1:0]  rem_q;
	logic [LEN_W+1:0]  dvs_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+1:0] racc_q;
	logic [RCNT_W-1:0] rcnt_q;
	logic [OUT_W-1:0]  mav_q, wmav_q;

	logic [LEN_W-1:0]  len_c;
	logic [LEN_W+2:0]  rem_sh;
	logic              div_end, root_end;
	logic [ROOT_W+1:0] racc_sh, rtrial;

	// clamp the window length the same way the top level clamps it before the front
	always_comb begin
		len_c = win.len;
		if (win.len < LEN_W'(LEN_MIN)) len_c = LEN_W'(LEN_MIN);
		if (win.len > LEN_W'(LEN_MAX)) len_c = LEN_W'(LEN_MAX);
	end

	always_comb begin
		rem_sh   = {rem_q, quo_q[DIV_W-1]};
		div_end  = dcnt_q == '0;
		racc_sh  = {racc_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
		rtrial   = {root_q, 2'b01};
		root_end = rcnt_q == '0;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:    if (win_avail) st_d = ST_DIV_SQ;
			ST_DIV_SQ:  if (div_end) st_d = ST_DIV_ABS;
			ST_DIV_ABS: if (div_end) st_d = ST_DIV_WD;
			ST_DIV_WD:  if (div_end) st_d = ST_SQRT;
			ST_SQRT:    if (root_end) st_d = ST_DONE;
			ST_DONE:    if (!res_valid || res_take) st_d = ST_IDLE;
			default:    st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		win_take = 1'b0;
		case (st_q)
			ST_IDLE: win_take = win_avail;
			default: win_take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			res_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (res_take) res_valid <= 1'b0;
			if (st_q == ST_DONE && (!res_valid || res_take)) res_valid <= 1'b1;
		end
	end

	// restoring divider, one quotient bit per cycle, shared by three divisions
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (win_avail) begin
				w_q    <= win;
				quo_q  <= win.sq_sum;
				rem_q  <= '0;
				dvs_q  <= (LEN_W+2)'(len_c);
				dcnt_q <= DCNT_W'(DIV_W);
			end
			ST_DIV_SQ, ST_DIV_ABS, ST_DIV_WD: begin
				if (!div_end) begin
					dcnt_q <= dcnt_q - 1'b1;
					if (rem_sh >= {1'b0, dvs_q}) begin
						rem_q <= (LEN_W+2)'(rem_sh - {1'b0, dvs_q});
						quo_q <= {quo_q[DIV_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[LEN_W+1:0];
						quo_q <= {quo_q[DIV_W-2:0], 1'b0};
					end
				end else begin
					rem_q  <= '0;
					dcnt_q <= DCNT_W'(DIV_W);
					case (st_q)
						ST_DIV_SQ: begin
							rad_q  <= {1'b0, quo_q};
							quo_q  <= DIV_W'(w_q.abs_sum);
						end
						ST_DIV_ABS: begin
							mav_q  <= (quo_q > DIV_W'({OUT_W{1'b1}})) ? '1 : OUT_W'(quo_q);
							quo_q  <= DIV_W'(w_q.wd_sum);
							dvs_q  <= (LEN_W+2)'({w_q.len, 1'b0});
						end
						default: begin
							wmav_q <= (quo_q > DIV_W'({OUT_W{1'b1}})) ? '1 : OUT_W'(quo_q);
							root_q <= '0;
							racc_q <= '0;
							rcnt_q <= RCNT_W'(ROOT_W);
						end
					endcase
				end
			end
			ST_SQRT: if (!root_end) begin
				// digit-by-digit root, two radicand bits per cycle
				rcnt_q <= rcnt_q - 1'b1;
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				if (racc_sh >= rtrial) begin
					racc_q <= racc_sh - rtrial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					racc_q <= racc_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			ST_DONE: if (!res_valid || res_take) begin
				res.square_integral        <= w_q.sq_sum;
				res.root_mean_square       <= (root_q > ROOT_W'({OUT_W{1'b1}})) ? '1
				                              : OUT_W'(root_q);
				res.waveform_length        <= w_q.diff_sum;
				res.mean_absolute          <= mav_q;
				res.weighted_mean_absolute <= wmav_q;
				res.slope_changes          <= w_q.slope_cnt;
			end
			default: ;
		endcase
	end

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		win_take |-> st_q == ST_IDLE) else $error("window taken while busy");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_take |=> res_valid) else $error("result dropped");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV_SQ |-> dvs_q >= (LEN_W+2)'(LEN_MIN)) else $error("divisor below minimum");

endmodule
